/* src/biou_pkg.sv */
`timescale 1ns / 1ps

package biou_pkg;

  localparam int COORD_BITS = 12;
  localparam int FRAC_BITS  = 16;
  localparam int SIZE_BITS  = COORD_BITS + 1;
  localparam int AREA_BITS  = 2 * COORD_BITS + 2;
  localparam int RATIO_BITS = FRAC_BITS + 1;

  typedef logic [COORD_BITS-1:0] coord_t;
  typedef logic [SIZE_BITS-1:0]  size_t;
  typedef logic [AREA_BITS-1:0]  area_t;
  typedef logic [RATIO_BITS-1:0] ratio_t;
  typedef logic [FRAC_BITS-1:0]  quo_t;

  localparam size_t  MAX_SIZE  = size_t'(1) << COORD_BITS;
  localparam ratio_t RATIO_ONE = ratio_t'(1) << FRAC_BITS;

  typedef struct packed {
    coord_t first_x;
    coord_t first_y;
    size_t  first_w;
    size_t  first_h;
    coord_t second_x;
    coord_t second_y;
    size_t  second_w;
    size_t  second_h;
  } in_t;

  typedef struct packed {
    logic   overlaps;
    coord_t overlap_x;
    coord_t overlap_y;
    size_t  overlap_w;
    size_t  overlap_h;
    area_t  union_area;
    ratio_t ratio_q16;
  } res_t;

  // Overlap box plus both box areas, out of the geometry stages.
  typedef struct packed {
    logic   overlaps;
    coord_t overlap_x;
    coord_t overlap_y;
    size_t  overlap_w;
    size_t  overlap_h;
    area_t  area_a;
    area_t  area_b;
  } geo_t;

  // Divider operands; the divisor is res.union_area.
  typedef struct packed {
    res_t  res;
    area_t num;
    logic  one;
  } dvd_t;

  // Zero size reads as one pixel, oversize saturates.
  function automatic size_t clamp_size(size_t s);
    size_t r;
    if (s == size_t'(0)) begin
      r = size_t'(1);
    end else if (s > MAX_SIZE) begin
      r = MAX_SIZE;
    end else begin
      r = s;
    end
    return r;
  endfunction

endpackage

/* src/biou_geom.sv */
`timescale 1ns / 1ps

module biou_geom (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          adv,
  input  logic          in_valid,
  input  biou_pkg::in_t in_data,
  output logic          out_valid,
  output biou_pkg::geo_t out_data
);

  // stage 1: clamped sizes and interval bounds
  logic                  vld1_r;
  biou_pkg::coord_t      lo_x_r, lo_y_r;
  biou_pkg::size_t       hi_x_r, hi_y_r;
  biou_pkg::size_t       aw_r, ah_r, bw_r, bh_r;

  biou_pkg::size_t       aw_nxt, ah_nxt, bw_nxt, bh_nxt;
  biou_pkg::size_t       a_end_x, b_end_x, a_end_y, b_end_y;
  biou_pkg::coord_t      lo_x_nxt, lo_y_nxt;
  biou_pkg::size_t       hi_x_nxt, hi_y_nxt;

  always_comb begin
    aw_nxt   = biou_pkg::clamp_size(in_data.first_w);
    ah_nxt   = biou_pkg::clamp_size(in_data.first_h);
    bw_nxt   = biou_pkg::clamp_size(in_data.second_w);
    bh_nxt   = biou_pkg::clamp_size(in_data.second_h);
    a_end_x  = biou_pkg::size_t'(in_data.first_x) + aw_nxt - biou_pkg::size_t'(1);
    b_end_x  = biou_pkg::size_t'(in_data.second_x) + bw_nxt - biou_pkg::size_t'(1);
    a_end_y  = biou_pkg::size_t'(in_data.first_y) + ah_nxt - biou_pkg::size_t'(1);
    b_end_y  = biou_pkg::size_t'(in_data.second_y) + bh_nxt - biou_pkg::size_t'(1);
    lo_x_nxt = (in_data.first_x > in_data.second_x) ? in_data.first_x : in_data.second_x;
    lo_y_nxt = (in_data.first_y > in_data.second_y) ? in_data.first_y : in_data.second_y;
    hi_x_nxt = (a_end_x < b_end_x) ? a_end_x : b_end_x;
    hi_y_nxt = (a_end_y < b_end_y) ? a_end_y : b_end_y;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
    end else if (adv) begin
      vld1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      lo_x_r <= lo_x_nxt;
      lo_y_r <= lo_y_nxt;
      hi_x_r <= hi_x_nxt;
      hi_y_r <= hi_y_nxt;
      aw_r   <= aw_nxt;
      ah_r   <= ah_nxt;
      bw_r   <= bw_nxt;
      bh_r   <= bh_nxt;
    end
  end

  // stage 2: overlap box and both areas
  logic           vld2_r;
  biou_pkg::geo_t geo_r;
  biou_pkg::geo_t geo_nxt;
  logic           hit_x, hit_y, hit;

  always_comb begin
    hit_x = biou_pkg::size_t'(lo_x_r) <= hi_x_r;
    hit_y = biou_pkg::size_t'(lo_y_r) <= hi_y_r;
    hit   = hit_x && hit_y;
    geo_nxt.overlaps = hit;
    if (hit) begin
      geo_nxt.overlap_x = lo_x_r;
      geo_nxt.overlap_y = lo_y_r;
      geo_nxt.overlap_w = hi_x_r - biou_pkg::size_t'(lo_x_r) + biou_pkg::size_t'(1);
      geo_nxt.overlap_h = hi_y_r - biou_pkg::size_t'(lo_y_r) + biou_pkg::size_t'(1);
    end else begin
      geo_nxt.overlap_x = '0;
      geo_nxt.overlap_y = '0;
      geo_nxt.overlap_w = '0;
      geo_nxt.overlap_h = '0;
    end
    geo_nxt.area_a = biou_pkg::area_t'(aw_r) * biou_pkg::area_t'(ah_r);
    geo_nxt.area_b = biou_pkg::area_t'(bw_r) * biou_pkg::area_t'(bh_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld2_r <= 1'b0;
    end else if (adv) begin
      vld2_r <= vld1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      geo_r <= geo_nxt;
    end
  end

  assign out_valid = vld2_r;
  assign out_data  = geo_r;

endmodule

/* src/biou_area.sv */
`timescale 1ns / 1ps

module biou_area (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           adv,
  input  logic           in_valid,
  input  biou_pkg::geo_t in_data,
  output logic           out_valid,
  output biou_pkg::dvd_t out_data
);

  // stage 3: intersection product and area sum
  logic            vld3_r;
  biou_pkg::geo_t  geo_r;
  biou_pkg::area_t inter_r, sum_r;
  biou_pkg::area_t inter_nxt, sum_nxt;

  always_comb begin
    inter_nxt = biou_pkg::area_t'(in_data.overlap_w) * biou_pkg::area_t'(in_data.overlap_h);
    sum_nxt   = in_data.area_a + in_data.area_b;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld3_r <= 1'b0;
    end else if (adv) begin
      vld3_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      geo_r   <= in_data;
      inter_r <= inter_nxt;
      sum_r   <= sum_nxt;
    end
  end

  // stage 4: union and the full-ratio flag
  logic            vld4_r;
  biou_pkg::dvd_t  dvd_r;
  biou_pkg::dvd_t  dvd_nxt;
  biou_pkg::area_t uni;

  always_comb begin
    uni                      = sum_r - inter_r;
    dvd_nxt.res.overlaps     = geo_r.overlaps;
    dvd_nxt.res.overlap_x    = geo_r.overlap_x;
    dvd_nxt.res.overlap_y    = geo_r.overlap_y;
    dvd_nxt.res.overlap_w    = geo_r.overlap_w;
    dvd_nxt.res.overlap_h    = geo_r.overlap_h;
    dvd_nxt.res.union_area   = uni;
    dvd_nxt.res.ratio_q16    = '0;
    dvd_nxt.num              = inter_r;
    dvd_nxt.one              = inter_r >= uni;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld4_r <= 1'b0;
    end else if (adv) begin
      vld4_r <= vld3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dvd_r <= dvd_nxt;
    end
  end

  assign out_valid = vld4_r;
  assign out_data  = dvd_r;

endmodule

/* src/biou_div.sv */
`timescale 1ns / 1ps

module biou_div (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           adv,
  input  logic           in_valid,
  input  biou_pkg::dvd_t in_data,
  output logic           out_valid,
  output biou_pkg::res_t out_data
);

  localparam int STEPS = biou_pkg::FRAC_BITS;

  // One restoring step per stage; the remainder stays below the divisor unless the two are equal.
  logic            vld_r [STEPS];
  biou_pkg::area_t rem_r [STEPS];
  biou_pkg::quo_t  quo_r [STEPS];
  biou_pkg::res_t  res_r [STEPS];
  logic            one_r [STEPS];

  for (genvar k = 0; k < STEPS; k++) begin : g_step
    logic                         vld_in;
    biou_pkg::area_t              rem_in;
    biou_pkg::quo_t               quo_in;
    biou_pkg::res_t               res_in;
    logic                         one_in;
    logic [biou_pkg::AREA_BITS:0] trial;
    logic [biou_pkg::AREA_BITS:0] den_x;
    logic [biou_pkg::AREA_BITS:0] diff;
    logic                         take;
    biou_pkg::area_t              rem_nxt;
    biou_pkg::quo_t               quo_nxt;

    if (k == 0) begin : g_head
      assign vld_in = in_valid;
      assign rem_in = in_data.num;
      assign quo_in = '0;
      assign res_in = in_data.res;
      assign one_in = in_data.one;
    end else begin : g_body
      assign vld_in = vld_r[k-1];
      assign rem_in = rem_r[k-1];
      assign quo_in = quo_r[k-1];
      assign res_in = res_r[k-1];
      assign one_in = one_r[k-1];
    end

    always_comb begin
      trial   = {rem_in, 1'b0};
      den_x   = {1'b0, res_in.union_area};
      diff    = trial - den_x;
      take    = trial >= den_x;
      rem_nxt = take ? diff[biou_pkg::AREA_BITS-1:0] : trial[biou_pkg::AREA_BITS-1:0];
      quo_nxt = {quo_in[STEPS-2:0], take};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (adv) begin
        vld_r[k] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        rem_r[k] <= rem_nxt;
        quo_r[k] <= quo_nxt;
        res_r[k] <= res_in;
        one_r[k] <= one_in;
      end
    end
  end

  always_comb begin
    out_data = res_r[STEPS-1];
    if (one_r[STEPS-1]) begin
      out_data.ratio_q16 = biou_pkg::RATIO_ONE;
    end else begin
      out_data.ratio_q16 = {1'b0, quo_r[STEPS-1]};
    end
  end

  assign out_valid = vld_r[STEPS-1];

endmodule

/* src/biou_obuf.sv */
`timescale 1ns / 1ps

module biou_obuf (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  biou_pkg::res_t in_data,
  output logic           adv,
  output logic           out_valid,
  input  logic           out_stall,
  output biou_pkg::res_t out_data
);

  // Two entries: the output register and a spare that catches the one
  // result still in flight when the pipeline is told to hold.
  logic [1:0]     cnt_r, cnt_nxt;
  biou_pkg::res_t head_r, head_nxt;
  biou_pkg::res_t spare_r, spare_nxt;
  logic           push, pop;

  assign adv       = (cnt_r != 2'd2);
  assign out_valid = (cnt_r != 2'd0);
  assign out_data  = head_r;

  always_comb begin
    push      = in_valid && adv;
    pop       = out_valid && !out_stall;
    cnt_nxt   = cnt_r;
    head_nxt  = head_r;
    spare_nxt = spare_r;
    case (cnt_r)
      2'd0: begin
        if (push) begin
          head_nxt = in_data;
          cnt_nxt  = 2'd1;
        end
      end
      2'd1: begin
        if (push && pop) begin
          head_nxt = in_data;
        end else if (push) begin
          spare_nxt = in_data;
          cnt_nxt   = 2'd2;
        end else if (pop) begin
          cnt_nxt = 2'd0;
        end
      end
      default: begin
        if (pop) begin
          head_nxt = spare_r;
          cnt_nxt  = 2'd1;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    head_r  <= head_nxt;
    spare_r <= spare_nxt;
  end

endmodule

/* src/box_iou_unit.sv */
`timescale 1ns / 1ps

// Intersection over union of two axis-aligned pixel boxes.
// Input channel (in_valid / in_stall / in_data): one box pair per transfer,
// each box as corner x, y and width, height; sizes clamp to 1..4096.
// Result channel (out_valid / out_stall / out_data): one result per pair, in
// order: overlap flag, overlap box (all zero when the boxes miss), union
// area and the ratio as unsigned Q1.16, truncated, with 65536 for one.
// Throughput: one pair per cycle, sustained, with no stall from the receiver.
// Pipeline from an input transfer to out_valid: four geometry and area
// stages, then sixteen divider stages (one quotient bit each), then the
// output register.
// Reset (rst_n low, synchronous) drops every item in flight and empties the
// output buffer; no configuration exists.
// When the receiver stalls, the result holds on out_data; one more result
// lands in a spare entry, then in_stall rises and the whole pipeline holds.
module box_iou_unit (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  biou_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output biou_pkg::res_t out_data
);

  // global advance for every pipeline stage; decoded from the buffer's registered count
  logic           adv;
  logic           geo_valid;
  biou_pkg::geo_t geo_data;
  logic           dvd_valid;
  biou_pkg::dvd_t dvd_data;
  logic           div_valid;
  biou_pkg::res_t div_data;

  // accept a transfer whenever the pipeline advances
  assign in_stall = !adv;

  // clamp, interval bounds, overlap box, box areas
  biou_geom u_geom (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (in_valid),
    .in_data   (in_data),
    .out_valid (geo_valid),
    .out_data  (geo_data)
  );

  // intersection area, union area
  biou_area u_area (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (geo_valid),
    .in_data   (geo_data),
    .out_valid (dvd_valid),
    .out_data  (dvd_data)
  );

  // pipelined fraction divider
  biou_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (dvd_valid),
    .in_data   (dvd_data),
    .out_valid (div_valid),
    .out_data  (div_data)
  );

  // output register plus spare; drives the advance
  biou_obuf u_obuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (div_valid),
    .in_data   (div_data),
    .adv       (adv),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

/* test/tb_box_iou_unit.sv */
`timescale 1ns / 1ps

module tb_box_iou_unit;
  import biou_pkg::*;

  // Watchdog: cycles in a row with no transfer on either channel.
  localparam int IDLE_LIMIT = 2000;
  // Receiver hold-off long enough to back the whole pipeline up.
  localparam int LONG_HOLD  = 150;
  // Settling time after the last expected result (pipeline is 21 deep).
  localparam int TAIL_WAIT  = 30;

  // Receiver stall styles.
  typedef enum int {RX_FREE, RX_RUNS, RX_HEAVY} rx_style_t;

  // Golden IoU model plus the in-order list of results still owed.
  class iou_scoreboard;
    res_t        owed[$];
    int unsigned errors;
    int unsigned checked;
    int unsigned hits;
    int unsigned unity;

    task report(string what);
      errors++;
      if (errors <= 20) $display("tb_box_iou_unit: mismatch: %s", what);
    endtask

    // Zero reads as one pixel, anything past 4096 saturates.
    function int unsigned fit_size(size_t s);
      int unsigned r;
      r = s;
      if (r == 0) r = 1;
      if (r > MAX_SIZE) r = MAX_SIZE;
      return r;
    endfunction

    // Overlap of two inclusive pixel runs; ends computed without wrap.
    function bit span(int unsigned a, int unsigned la, int unsigned b, int unsigned lb,
                      output int unsigned lo, output int unsigned len);
      int unsigned hi;
      lo = (a > b) ? a : b;
      hi = ((a + la - 1) < (b + lb - 1)) ? (a + la - 1) : (b + lb - 1);
      len = (lo > hi) ? 0 : hi - lo + 1;
      return lo <= hi;
    endfunction

    function res_t iou_of(in_t p);
      int unsigned     aw, ah, bw, bh, ox, oy, ow, oh;
      bit              hit_x, hit_y;
      longint unsigned inter, uni;
      res_t            r;
      aw = fit_size(p.first_w);
      ah = fit_size(p.first_h);
      bw = fit_size(p.second_w);
      bh = fit_size(p.second_h);
      hit_x = span(p.first_x, aw, p.second_x, bw, ox, ow);
      hit_y = span(p.first_y, ah, p.second_y, bh, oy, oh);
      r = '0;
      inter = 0;
      if (hit_x && hit_y) begin
        // Overlap box only stands when both axes meet.
        r.overlaps  = 1'b1;
        r.overlap_x = coord_t'(ox);
        r.overlap_y = coord_t'(oy);
        r.overlap_w = size_t'(ow);
        r.overlap_h = size_t'(oh);
        inter = longint'(ow) * oh;
      end
      uni = longint'(aw) * ah + longint'(bw) * bh - inter;
      r.union_area = area_t'(uni);
      if (inter >= uni) begin
        r.ratio_q16 = RATIO_ONE;
      end else begin
        r.ratio_q16 = ratio_t'((inter << FRAC_BITS) / uni);
      end
      return r;
    endfunction

    function void note_pair(in_t p);
      owed.push_back(iou_of(p));
    endfunction

    task compare(string name, logic [31:0] got, logic [31:0] want);
      if (got !== want) begin
        report($sformatf("result %0d %s: got %0d, want %0d", checked, name, got, want));
      end
    endtask

    task check_result(res_t got);
      res_t want;
      if (owed.size() == 0) begin
        report($sformatf("result with no pair waiting: %h", got));
        return;
      end
      want = owed.pop_front();
      checked++;
      if (want.overlaps) hits++;
      if (want.ratio_q16 == RATIO_ONE) unity++;
      compare("overlaps", got.overlaps, want.overlaps);
      compare("overlap_x", got.overlap_x, want.overlap_x);
      compare("overlap_y", got.overlap_y, want.overlap_y);
      compare("overlap_w", got.overlap_w, want.overlap_w);
      compare("overlap_h", got.overlap_h, want.overlap_h);
      compare("union_area", got.union_area, want.union_area);
      compare("ratio_q16", got.ratio_q16, want.ratio_q16);
    endtask

    task flag_leftovers();
      if (owed.size() != 0) report($sformatf("%0d results never arrived", owed.size()));
    endtask
  endclass

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_t       in_data   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  res_t      out_data;

  iou_scoreboard sb;
  rx_style_t     rx_style      = RX_FREE;
  bit            long_hold_req = 1'b0;
  int unsigned   pairs_sent    = 0;
  int unsigned   quiet_cycles  = 0;

  box_iou_unit u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Sample both channels at the rising edge; a transfer is valid with no stall.
  // The watchdog shares this block so it sees the same transfers.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) sb.note_pair(in_data);
      if (out_valid && !out_stall) sb.check_result(out_data);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles == IDLE_LIMIT) begin
        $display("tb_box_iou_unit: no transfer for %0d cycles", IDLE_LIMIT);
        $display("tb_box_iou_unit: done, errors");
        $finish;
      end
    end
  end

  // Receiver: one stall update per falling edge. A long hold-off, when asked
  // for, is counted here while the sender keeps offering pairs.
  initial begin : receiver
    int unsigned hold_left;
    int unsigned run_left;
    bit          run_stalled;
    hold_left   = 0;
    run_left    = 0;
    run_stalled = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold_req && hold_left == 0) begin
        hold_left     = LONG_HOLD;
        long_hold_req = 1'b0;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        case (rx_style)
          RX_FREE: begin
            out_stall <= 1'b0;
          end
          RX_RUNS: begin
            // Stalled and open runs of random length; one run in three is stalled.
            if (run_left == 0) begin
              run_stalled = ($urandom_range(0, 2) == 0);
              run_left    = $urandom_range(1, 12);
            end
            run_left--;
            out_stall <= run_stalled;
          end
          default: begin
            out_stall <= ($urandom_range(0, 3) != 0);
          end
        endcase
      end
    end
  end

  // Offer one pair and hold it until the transfer happens.
  task automatic send_pair(in_t p);
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= p;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pairs_sent++;
  endtask

  task automatic idle_for(int unsigned n);
    repeat (n) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
  endtask

  // Drop valid and wait until every owed result has come back.
  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.owed.size() != 0) @(posedge clk);
  endtask

  function automatic in_t pair_of(int ax, int ay, int aw, int ah,
                                  int bx, int by, int bw, int bh);
    in_t p;
    p.first_x  = coord_t'(ax);
    p.first_y  = coord_t'(ay);
    p.first_w  = size_t'(aw);
    p.first_h  = size_t'(ah);
    p.second_x = coord_t'(bx);
    p.second_y = coord_t'(by);
    p.second_w = size_t'(bw);
    p.second_h = size_t'(bh);
    return p;
  endfunction

  // Mostly small boxes, some up to full frame, a few zero or oversize.
  function automatic size_t rand_size();
    int unsigned k;
    k = $urandom_range(0, 99);
    if (k < 55) return size_t'($urandom_range(1, 32));
    if (k < 80) return size_t'($urandom_range(1, 512));
    if (k < 94) return size_t'($urandom_range(1, 4096));
    if (k < 97) return ($urandom_range(0, 1) != 0) ? size_t'(0) : MAX_SIZE;
    return size_t'($urandom_range(4097, 8191));
  endfunction

  function automatic int eff(size_t s);
    if (s == 0) return 1;
    if (s > MAX_SIZE) return MAX_SIZE;
    return s;
  endfunction

  // Most pairs sit near each other so the overlap path gets real work;
  // the rest are identical boxes or land anywhere.
  function automatic in_t random_pair();
    in_t         p;
    int unsigned k;
    p.first_x  = coord_t'($urandom);
    p.first_y  = coord_t'($urandom);
    p.first_w  = rand_size();
    p.first_h  = rand_size();
    p.second_w = rand_size();
    p.second_h = rand_size();
    k = $urandom_range(0, 99);
    if (k < 5) begin
      p.second_x = p.first_x;
      p.second_y = p.first_y;
      p.second_w = p.first_w;
      p.second_h = p.first_h;
    end else if (k < 75) begin
      p.second_x = coord_t'(int'(p.first_x) - eff(p.second_w)
                   + int'($urandom_range(0, eff(p.first_w) + eff(p.second_w))));
      p.second_y = coord_t'(int'(p.first_y) - eff(p.second_h)
                   + int'($urandom_range(0, eff(p.first_h) + eff(p.second_h))));
    end else begin
      p.second_x = coord_t'($urandom);
      p.second_y = coord_t'($urandom);
    end
    return p;
  endfunction

  // Send n random pairs in bursts; gaps between bursts when asked, and
  // often none even then.
  task automatic send_random(int unsigned n, bit with_gaps);
    int unsigned left;
    int unsigned burst;
    left = n;
    while (left != 0) begin
      burst = $urandom_range(1, 40);
      if (burst > left) burst = left;
      repeat (burst) send_pair(random_pair());
      left -= burst;
      if (with_gaps && $urandom_range(0, 2) != 0) idle_for($urandom_range(1, 8));
    end
  endtask

  initial begin : stimulus
    in_t directed[$];
    sb = new();

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Identical boxes: ratio exactly one.
    directed.push_back(pair_of(10, 20, 5, 7, 10, 20, 5, 7));
    // Full frame on both sides: union 2^24, ratio one.
    directed.push_back(pair_of(0, 0, 4096, 4096, 0, 0, 4096, 4096));
    // Largest union: full frames sharing only one corner pixel.
    directed.push_back(pair_of(0, 0, 4096, 4096, 4095, 4095, 4096, 4096));
    // Boxes running past the last column and row.
    directed.push_back(pair_of(4095, 4095, 4096, 4096, 4095, 4095, 4096, 4096));
    // Miss on x while y overlaps, then the reverse.
    directed.push_back(pair_of(0, 0, 10, 10, 20, 0, 10, 10));
    directed.push_back(pair_of(0, 0, 10, 10, 0, 20, 10, 10));
    // Touching edges share no pixel; one column further they share one.
    directed.push_back(pair_of(0, 0, 10, 10, 10, 0, 10, 10));
    directed.push_back(pair_of(0, 0, 10, 10, 9, 0, 10, 10));
    // Single pixels, same and diagonal neighbors.
    directed.push_back(pair_of(4095, 0, 1, 1, 4095, 0, 1, 1));
    directed.push_back(pair_of(0, 0, 1, 1, 1, 1, 1, 1));
    // Containment both ways.
    directed.push_back(pair_of(100, 100, 1000, 1000, 200, 300, 10, 20));
    directed.push_back(pair_of(200, 300, 10, 20, 100, 100, 1000, 1000));
    // Zero sizes read as one pixel.
    directed.push_back(pair_of(5, 5, 0, 0, 5, 5, 1, 1));
    directed.push_back(pair_of(5, 5, 0, 3, 4, 4, 3, 0));
    // Oversize saturates to a full frame.
    directed.push_back(pair_of(0, 0, 8191, 8191, 0, 0, 4096, 4096));
    directed.push_back(pair_of(3000, 0, 4097, 5, 0, 0, 4097, 5));
    directed.push_back(pair_of(4095, 4095, 8191, 8191, 4095, 4095, 8191, 8191));
    // Overlap too small to show in the ratio: truncates to zero.
    directed.push_back(pair_of(0, 0, 1, 1, 0, 0, 4096, 4096));
    directed.push_back(pair_of(4095, 4095, 1, 1, 0, 0, 4096, 4096));
    // One third, truncated.
    directed.push_back(pair_of(0, 0, 2, 1, 1, 0, 2, 1));
    foreach (directed[i]) send_pair(directed[i]);

    // Sender pause: everything owed must come home before going on.
    wait_drained();

    // Bursty sender against a run-length stall pattern.
    rx_style = RX_RUNS;
    send_random(600, 1'b1);

    // Long receiver hold-off while pairs keep coming: fill up and back-pressure.
    long_hold_req = 1'b1;
    send_random(100, 1'b0);
    wait_drained();

    // Full rate both ways.
    rx_style = RX_FREE;
    send_random(200, 1'b0);

    // Heavy stalls with gaps, then a clean run-length stretch.
    rx_style = RX_HEAVY;
    send_random(250, 1'b1);
    rx_style = RX_RUNS;
    send_random(180, 1'b1);

    wait_drained();
    repeat (TAIL_WAIT) @(posedge clk);
    sb.flag_leftovers();

    $display("tb_box_iou_unit: %0d box pairs sent, %0d results checked", pairs_sent,
             sb.checked);
    $display("tb_box_iou_unit: %0d overlapping, %0d with ratio one, %0d mismatches",
             sb.hits, sb.unity, sb.errors);
    if (sb.errors == 0) begin
      $display("tb_box_iou_unit: done, clean");
    end else begin
      $display("tb_box_iou_unit: done, errors");
    end
    $finish;
  end

endmodule
